### design/binary_trie_max_xor_macros.svh
// Assertion macros for the binary trie maximum-xor block.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTMX_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btmx assertion failed in %m");

// Next-cycle implication, checked outside reset.
`define BTMX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btmx assertion failed in %m");

`endif

### design/btmx_pkg.sv
// Shared types, codes and the microcode table of the binary trie maximum-xor block.
// Depends on nothing; used by the channel interfaces and the top level.
package btmx_pkg;

    // Default sizes of the node store and of the stored values.
    localparam int NODE_COUNT_DEF = 8192;
    localparam int VALUE_BITS_DEF = 32;

    // Field widths of the request and response channels.
    localparam int REQ_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Microprogram step addresses.
    typedef logic [2:0] step_t;
    localparam step_t S_FETCH    = 3'd0;
    localparam step_t S_INS_CHK  = 3'd1;
    localparam step_t S_INS_WALK = 3'd2;
    localparam step_t S_QRY_CHK  = 3'd3;
    localparam step_t S_QRY_WALK = 3'd4;
    localparam step_t S_CLEAR    = 3'd5;
    localparam step_t S_RESP     = 3'd6;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_INS_START,
        DP_INS_STEP,
        DP_QRY_START,
        DP_QRY_STEP,
        DP_CLEAR,
        DP_RESPOND
    } dp_op_t;

    // How the step counter moves.
    typedef enum logic [1:0] {
        J_GOTO_IF,
        J_HOLD_UNTIL,
        J_DISPATCH
    } jump_t;

    // Condition tested by a jump.
    typedef enum logic [2:0] {
        C_TRUE,
        C_FULL,
        C_EMPTY,
        C_LAST,
        C_OUT_FREE
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        dp_op_t dp;
        jump_t  jump;
        cond_t  cond;
        step_t  target;
    } ctl_t;

    // The microprogram: one control word per step.
    function automatic ctl_t ucode_rom(input step_t s);
        ctl_t w;
        begin
            unique case (s)
                S_FETCH:    w = '{dp: DP_ACCEPT,    jump: J_DISPATCH,   cond: C_TRUE,
                                  target: S_FETCH};
                S_INS_CHK:  w = '{dp: DP_INS_START, jump: J_GOTO_IF,    cond: C_FULL,
                                  target: S_RESP};
                S_INS_WALK: w = '{dp: DP_INS_STEP,  jump: J_HOLD_UNTIL, cond: C_LAST,
                                  target: S_RESP};
                S_QRY_CHK:  w = '{dp: DP_QRY_START, jump: J_GOTO_IF,    cond: C_EMPTY,
                                  target: S_RESP};
                S_QRY_WALK: w = '{dp: DP_QRY_STEP,  jump: J_HOLD_UNTIL, cond: C_LAST,
                                  target: S_RESP};
                S_CLEAR:    w = '{dp: DP_CLEAR,     jump: J_GOTO_IF,    cond: C_TRUE,
                                  target: S_RESP};
                S_RESP:     w = '{dp: DP_RESPOND,   jump: J_HOLD_UNTIL, cond: C_OUT_FREE,
                                  target: S_FETCH};
                default:    w = '{dp: DP_NONE,      jump: J_GOTO_IF,    cond: C_TRUE,
                                  target: S_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

### design/btmx_ifs.sv
// Valid/ready channel interfaces for requests and responses of the trie block.
// Depends on btmx_pkg for the field widths.
interface btmx_req_if
    import btmx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface btmx_rsp_if
    import btmx_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   best_xor;
    logic [DATA_W-1:0]   running_max;
    logic [STATUS_W-1:0] status;

    modport source (output valid, best_xor, running_max, status, input ready);
    modport sink   (input valid, best_xor, running_max, status, output ready);
endinterface

### design/binary_trie_max_xor.sv
// Top level of the binary trie maximum-xor block: microcoded sequencer and node store.
// Depends on btmx_pkg, the channel interfaces in btmx_ifs.sv and the assertion macros.
//
// Usage:
// - Requests arrive on req (req_type, value); a transaction completes when valid and
//   ready are both high. Insert adds value to the set, query returns the largest xor
//   of value with a stored value, clear empties the set and the running maximum.
// - Each request yields exactly one response transaction on rsp (best_xor,
//   running_max, status), held in an output register until the receiver takes it.
// - Insert and query check the request, read the node store once per trie level and
//   then load the output register. Clear, a rejected insert and a query on an empty
//   set skip the walk, and an unused code goes straight to the respond step. The node
//   store's single read port sets one level a cycle.
// - One request is in flight at a time; req.ready is high only in the fetch step.
// - If the receiver stalls, the block finishes the current request and waits in the
//   respond step until the output register is free, then loads it and fetches again.
// - Reset empties the set and zeroes the running maximum at once; no clearing pass is
//   needed because the root is marked empty and new nodes are cleared as they are
//   first written.
`include "binary_trie_max_xor_macros.svh"

module binary_trie_max_xor
    import btmx_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    btmx_req_if.sink  req,
    btmx_rsp_if.source rsp
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [AW:0]   NODE_LIMIT = (AW+1)'(NODE_COUNT);
    localparam logic [AW:0]   WALK_NODES = (AW+1)'(VALUE_BITS);
    localparam logic [LW-1:0] TOP_LEVEL  = LW'(VALUE_BITS - 1);

    // Node store: child pointers, zero means no child.
    logic [AW-1:0] child_zero_mem [NODE_COUNT];
    logic [AW-1:0] child_one_mem  [NODE_COUNT];

    // Sequencer.
    step_t step_reg, step_next;
    ctl_t  ctl;
    logic  cond_hit;

    // Datapath registers.
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [LW-1:0]         level_reg, level_next;
    logic [AW-1:0]         node_reg, node_next;
    logic                  fresh_reg, fresh_next;
    logic [AW:0]           next_free_reg, next_free_next;
    logic                  set_nonempty_reg, set_nonempty_next;
    logic                  root_empty_reg, root_empty_next;
    logic [DATA_W-1:0]     best_so_far_reg, best_so_far_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_best_reg, out_best_next;
    logic [DATA_W-1:0]     out_max_reg, out_max_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    // Node store ports.
    logic [AW-1:0] rd_zero_reg, rd_one_reg;
    logic          wr_en;
    logic [AW-1:0] wr_zero, wr_one;

    // Helpers.
    logic                  req_fire;
    logic                  out_free;
    logic                  store_full;
    logic                  last_level;
    logic                  cur_bit;
    logic [AW-1:0]         cz, co;
    logic [AW-1:0]         same_child, other_child;
    logic [AW-1:0]         new_node;
    logic                  alloc;
    logic [VALUE_BITS-1:0] level_mask;
    logic [VALUE_BITS-1:0] acc_cand;
    logic [DATA_W-1:0]     cand32;

    // Control word of the current step and the handshake.
    assign ctl      = ucode_rom(step_reg);
    assign req.ready = (ctl.dp == DP_ACCEPT);
    assign req_fire = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.best_xor    = out_best_reg;
    assign rsp.running_max = out_max_reg;
    assign rsp.status      = out_status_reg;

    // One level of the walk: children of the current node, masked when it is fresh.
    assign store_full  = (NODE_LIMIT - next_free_reg) < WALK_NODES;
    assign last_level  = (level_reg == '0);
    assign cur_bit     = value_reg[level_reg];
    assign cz          = fresh_reg ? '0 : rd_zero_reg;
    assign co          = fresh_reg ? '0 : rd_one_reg;
    assign same_child  = cur_bit ? co : cz;
    assign other_child = cur_bit ? cz : co;
    assign new_node    = next_free_reg[AW-1:0];
    assign alloc       = (same_child == '0);
    assign level_mask  = VALUE_BITS'(1) << level_reg;
    assign acc_cand    = (other_child != '0) ? (acc_reg | level_mask) : acc_reg;
    assign cand32      = DATA_W'(acc_cand);

    // Condition select for the jump.
    always_comb
    begin
        unique case (ctl.cond)
            C_TRUE:     cond_hit = 1'b1;
            C_FULL:     cond_hit = store_full;
            C_EMPTY:    cond_hit = !set_nonempty_reg;
            C_LAST:     cond_hit = last_level;
            C_OUT_FREE: cond_hit = out_free;
            default:    cond_hit = 1'b0;
        endcase
    end

    // Step counter: advance, hold, jump or dispatch on the request code.
    always_comb
    begin
        step_next = step_reg;
        unique case (ctl.jump)
            J_GOTO_IF:
            begin
                step_next = cond_hit ? ctl.target : step_t'(step_reg + 3'd1);
            end
            J_HOLD_UNTIL:
            begin
                step_next = cond_hit ? ctl.target : step_reg;
            end
            J_DISPATCH:
            begin
                if (req_fire)
                begin
                    unique case (req.req_type)
                        REQ_INSERT: step_next = S_INS_CHK;
                        REQ_QUERY:  step_next = S_QRY_CHK;
                        REQ_CLEAR:  step_next = S_CLEAR;
                        default:    step_next = S_RESP;
                    endcase
                end
            end
            default:
            begin
                step_next = S_FETCH;
            end
        endcase
    end

    // Datapath driven by the control word.
    always_comb
    begin
        value_next        = value_reg;
        acc_next          = acc_reg;
        level_next        = level_reg;
        node_next         = node_reg;
        fresh_next        = fresh_reg;
        next_free_next    = next_free_reg;
        set_nonempty_next = set_nonempty_reg;
        root_empty_next   = root_empty_reg;
        best_so_far_next  = best_so_far_reg;
        status_next       = status_reg;
        out_best_next     = out_best_reg;
        out_max_next      = out_max_reg;
        out_status_next   = out_status_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        wr_en             = 1'b0;
        wr_zero           = cz;
        wr_one            = co;

        unique case (ctl.dp)
            DP_NONE:
            begin
                wr_en = 1'b0;
            end
            DP_ACCEPT:
            begin
                if (req_fire)
                begin
                    value_next  = VALUE_BITS'(req.value);
                    acc_next    = '0;
                    status_next = ST_OK;
                end
            end
            DP_INS_START:
            begin
                if (store_full)
                begin
                    status_next = ST_FULL;
                end
                node_next  = '0;
                level_next = TOP_LEVEL;
                fresh_next = root_empty_reg;
            end
            DP_INS_STEP:
            begin
                // A missing child is allocated; the other side of a fresh node is zeroed.
                if (alloc)
                begin
                    wr_en          = 1'b1;
                    wr_zero        = cur_bit ? cz : new_node;
                    wr_one         = cur_bit ? new_node : co;
                    next_free_next = next_free_reg + 1'b1;
                    node_next      = new_node;
                    fresh_next     = 1'b1;
                end
                else
                begin
                    node_next  = same_child;
                    fresh_next = 1'b0;
                end
                root_empty_next = 1'b0;
                level_next      = level_reg - 1'b1;
                if (last_level)
                begin
                    set_nonempty_next = 1'b1;
                end
            end
            DP_QRY_START:
            begin
                if (!set_nonempty_reg)
                begin
                    status_next = ST_EMPTY;
                end
                node_next  = '0;
                level_next = TOP_LEVEL;
                fresh_next = root_empty_reg;
            end
            DP_QRY_STEP:
            begin
                // Prefer the child opposite to the query bit.
                acc_next   = acc_cand;
                node_next  = (other_child != '0) ? other_child : same_child;
                level_next = level_reg - 1'b1;
                if (last_level && (cand32 > best_so_far_reg))
                begin
                    best_so_far_next = cand32;
                end
            end
            DP_CLEAR:
            begin
                root_empty_next   = 1'b1;
                next_free_next    = (AW+1)'(1);
                set_nonempty_next = 1'b0;
                best_so_far_next  = '0;
            end
            DP_RESPOND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_best_next   = DATA_W'(acc_reg);
                    out_max_next    = best_so_far_reg;
                    out_status_next = status_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= S_FETCH;
            next_free_reg    <= (AW+1)'(1);
            set_nonempty_reg <= 1'b0;
            root_empty_reg   <= 1'b1;
            best_so_far_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            next_free_reg    <= next_free_next;
            set_nonempty_reg <= set_nonempty_next;
            root_empty_reg   <= root_empty_next;
            best_so_far_reg  <= best_so_far_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        acc_reg        <= acc_next;
        level_reg      <= level_next;
        node_reg       <= node_next;
        fresh_reg      <= fresh_next;
        status_reg     <= status_next;
        out_best_reg   <= out_best_next;
        out_max_reg    <= out_max_next;
        out_status_reg <= out_status_next;
    end

    // Node store: one write of the current node, one registered read of the next node.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            child_zero_mem[node_reg] <= wr_zero;
            child_one_mem[node_reg]  <= wr_one;
        end
        rd_zero_reg <= child_zero_mem[node_next];
        rd_one_reg  <= child_one_mem[node_next];
    end

    // A response is loaded only by the respond step.
    `BTMX_ASSERT_IMPLY(a_rsp_from_resp_step, $rose(out_valid_reg), $past(step_reg == S_RESP))
    // An allocation never goes past the end of the node store.
    `BTMX_ASSERT_IMPLY(a_alloc_in_range, (ctl.dp == DP_INS_STEP) && alloc,
                       next_free_reg < NODE_LIMIT)
    // A query walk only runs over a populated trie.
    `BTMX_ASSERT_IMPLY(a_query_nonempty, ctl.dp == DP_QRY_STEP,
                       set_nonempty_reg && !root_empty_reg)
    // A request transaction is followed by a cycle with the request channel closed.
    `BTMX_ASSERT_NEXT(a_one_in_flight, req_fire, !req.ready)

endmodule
